// ----- rtl/core/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and codes for the keyed compacting list.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned LABEL_W  = 64;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned ENTRY_W  = KEY_W + LABEL_W + PRICE_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_ENTRY     = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd6;

  typedef struct packed {
    logic                load_req;
    logic                clr_idx;
    logic                inc_idx;
    logic                ram_re;
    logic                sel_next;
    logic                wr_shift;
    logic                wr_append;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                out_load;
    logic                out_entry;
    logic [STATUS_W-1:0] out_status;
  } kcl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              key_match;
    logic              idx_last;
    logic              shift_last;
    logic              cnt_zero;
    logic              full;
    logic              out_free;
  } kcl_stat_t;

endpackage

// ----- rtl/core/kcl_ram.sv -----
// ----------------------------------------------------------------------------
// kcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcl_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/kcl_datapath.sv -----
// ----------------------------------------------------------------------------
// kcl_datapath
// Entry storage, walk index, count, capacity register and output word.
// ----------------------------------------------------------------------------
module kcl_datapath import kcl_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kcl_cmd_t                   cmd_i,
  output kcl_stat_t                  stat_o,
  input  logic                       cfg_we_i,
  input  logic [CAP_W-1:0]           cfg_wdata_i,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic signed [KEY_W-1:0]    key_i,
  input  logic [LABEL_W-1:0]         label_i,
  input  logic [PRICE_W-1:0]         price_cents_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [KEY_W-1:0]    entry_key_o,
  output logic [LABEL_W-1:0]         entry_label_o,
  output logic [PRICE_W-1:0]         entry_price_o,
  output logic [FILL_W-1:0]          fill_o,
  output logic                       last_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [IW-1:0]       idx_q, idx_d, idx_next;
  logic [CW-1:0]       cnt_q, cnt_d, idx_inc;
  logic [CAP_W-1:0]    cap_q;
  logic [KIND_W-1:0]   kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [LABEL_W-1:0]  label_q;
  logic [PRICE_W-1:0]  price_q;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [LABEL_W-1:0]  rd_label;
  logic [PRICE_W-1:0]  rd_price;

  logic                out_valid_q;
  logic                out_free;
  logic [STATUS_W-1:0] status_q;
  logic [KEY_W-1:0]    okey_q;
  logic [LABEL_W-1:0]  olabel_q;
  logic [PRICE_W-1:0]  oprice_q;
  logic [FILL_W-1:0]   fill_q;
  logic                last_q;

  assign rd_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
  assign rd_label = ram_rdata[PRICE_W +: LABEL_W];
  assign rd_price = ram_rdata[PRICE_W-1:0];

  assign idx_next  = idx_q + IW'(1);
  assign idx_inc   = CW'(idx_q) + CW'(1);
  assign ram_raddr = cmd_i.sel_next ? idx_next : idx_q;
  assign ram_waddr = cmd_i.wr_append ? cnt_q[IW-1:0] : idx_q;
  assign ram_wdata = cmd_i.wr_append ? {key_q, label_q, price_q} : ram_rdata;
  assign ram_we    = cmd_i.wr_append | cmd_i.wr_shift;

  kcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_idx) begin
      idx_d = '0;
    end else if (cmd_i.inc_idx) begin
      idx_d = idx_next;
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      cap_q <= CAP_RESET;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      label_q <= label_i;
      price_q <= price_cents_i;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      fill_q   <= FILL_W'(cnt_q);
      if (cmd_i.out_entry) begin
        okey_q   <= rd_key;
        olabel_q <= rd_label;
        oprice_q <= rd_price;
        last_q   <= (idx_inc == cnt_q);
      end else begin
        okey_q   <= key_q;
        olabel_q <= '0;
        oprice_q <= '0;
        last_q   <= 1'b1;
      end
    end
  end

  assign stat_o.kind       = kind_q;
  assign stat_o.key_match  = (rd_key == key_q);
  assign stat_o.idx_last   = (idx_inc == cnt_q);
  assign stat_o.shift_last = ((idx_inc + CW'(1)) == cnt_q);
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.full       = (MW'(cnt_q) >= MW'(cap_q)) || (cnt_q >= DepthC);
  assign stat_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_key_o   = okey_q;
  assign entry_label_o = olabel_q;
  assign entry_price_o = oprice_q;
  assign fill_o        = fill_q;
  assign last_o        = last_q;

endmodule

// ----- rtl/core/kcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// kcl_ctrl
// Sequencer for insert, remove and list: search, shift and emit steps.
// ----------------------------------------------------------------------------
module kcl_ctrl import kcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  kcl_stat_t stat_i,
  output kcl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_SCMP   = 3'd2;
  localparam logic [2:0] S_SHRD   = 3'd3;
  localparam logic [2:0] S_SHWR   = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;
  localparam logic [2:0] S_LEMIT  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [STATUS_W-1:0] resp_q, resp_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.clr_idx  = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.kind)
          KIND_INSERT: begin
            if (stat_i.full) begin
              resp_d  = STAT_FULL;
              state_d = S_RESP;
            end else if (stat_i.cnt_zero) begin
              state_d = S_APPEND;
            end else begin
              cmd_o.ram_re = 1'b1;
              state_d      = S_SCMP;
            end
          end
          KIND_REMOVE: begin
            if (stat_i.cnt_zero) begin
              resp_d  = STAT_NOT_FOUND;
              state_d = S_RESP;
            end else begin
              cmd_o.ram_re = 1'b1;
              state_d      = S_SCMP;
            end
          end
          KIND_LIST: begin
            if (stat_i.cnt_zero) begin
              resp_d  = STAT_EMPTY;
              state_d = S_RESP;
            end else begin
              cmd_o.ram_re = 1'b1;
              state_d      = S_LEMIT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCMP: begin
        if (stat_i.key_match) begin
          if (stat_i.kind == KIND_INSERT) begin
            resp_d  = STAT_DUPLICATE;
            state_d = S_RESP;
          end else if (stat_i.idx_last) begin
            cmd_o.cnt_dec = 1'b1;
            resp_d        = STAT_REMOVED;
            state_d       = S_RESP;
          end else begin
            cmd_o.ram_re   = 1'b1;
            cmd_o.sel_next = 1'b1;
            state_d        = S_SHWR;
          end
        end else if (stat_i.idx_last) begin
          if (stat_i.kind == KIND_INSERT) begin
            state_d = S_APPEND;
          end else begin
            resp_d  = STAT_NOT_FOUND;
            state_d = S_RESP;
          end
        end else begin
          // fetch the next entry while stepping the index
          cmd_o.ram_re   = 1'b1;
          cmd_o.sel_next = 1'b1;
          cmd_o.inc_idx  = 1'b1;
        end
      end
      S_SHRD: begin
        cmd_o.ram_re   = 1'b1;
        cmd_o.sel_next = 1'b1;
        state_d        = S_SHWR;
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        if (stat_i.shift_last) begin
          cmd_o.cnt_dec = 1'b1;
          resp_d        = STAT_REMOVED;
          state_d       = S_RESP;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = S_SHRD;
        end
      end
      S_APPEND: begin
        cmd_o.wr_append = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        resp_d          = STAT_INSERTED;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = resp_q;
          state_d          = S_IDLE;
        end
      end
      S_LEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_entry  = 1'b1;
          cmd_o.out_status = STAT_ENTRY;
          if (stat_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ram_re   = 1'b1;
            cmd_o.sel_next = 1'b1;
            cmd_o.inc_idx  = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= STAT_INSERTED;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

endmodule

// ----- rtl/core/keyed_compacting_list_top.sv -----
// ----------------------------------------------------------------------------
// keyed_compacting_list_top
// Ordered table of unique keyed entries with insert, remove and list.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Word
// in        input      in_valid_i/in_ready_o  kind, key, label, price_cents
// out       output     out_valid_o/out_ready_i status, entry fields, fill, last
// cfg       input      cfg_we_i               capacity
//
// Insert searches the held entries for the key and appends it when absent and not full.
// Remove searches for the key and moves each later entry down one place.
// List emits each held entry in turn. All steps share the single read port
// of the entry RAM. One word is worked on at a time; a stalled output holds
// the sequencer. Reset empties the table and sets capacity to 16; no clearing
// pass.
// ----------------------------------------------------------------------------
module keyed_compacting_list_top import kcl_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic [LABEL_W-1:0]      label_i,
  input  logic [PRICE_W-1:0]      price_cents_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic signed [KEY_W-1:0] entry_key_o,
  output logic [LABEL_W-1:0]      entry_label_o,
  output logic [PRICE_W-1:0]      entry_price_o,
  output logic [FILL_W-1:0]       fill_o,
  output logic                    last_o
);

  kcl_cmd_t  cmd;
  kcl_stat_t stat;

  kcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kcl_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .label_i       (label_i),
    .price_cents_i (price_cents_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_key_o   (entry_key_o),
    .entry_label_o (entry_label_o),
    .entry_price_o (entry_price_o),
    .fill_o        (fill_o),
    .last_o        (last_o)
  );

endmodule

// ----- rtl/core/kcl_checker.sv -----
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks on the keyed compacting list, bound to the top level.
// ----------------------------------------------------------------------------
module kcl_checker import kcl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [FILL_W-1:0]   fill_o,
  input logic                last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("output word dropped or changed while stalled");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_ENTRY |-> last_o)
    else $error("single-result word without last mark");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> fill_o == '0)
    else $error("empty status with nonzero fill");

  a_entry_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_ENTRY |-> fill_o != '0)
    else $error("listed entry with zero fill");

endmodule

bind keyed_compacting_list_top kcl_checker u_kcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .fill_o      (fill_o),
  .last_o      (last_o)
);
